// ===== hdl/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    // default sizes
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CAP_W      = 5;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_SIGNED   = 1'b1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic             SIGNED_RESET   = 1'b1;

    // operation codes
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // configuration handed to the datapath
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             signed_cmp;
    } cfg_t;

endpackage

// ===== hdl/mts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int DEPTH = mts_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = mts_pkg::DATA_WIDTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mts_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_apb_regs
// APB-style register file holding capacity limit and compare signedness.
// ----------------------------------------------------------------------------
module mts_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mts_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output mts_pkg::cfg_t                   cfg
);

    logic [mts_pkg::CAP_W-1:0] capacity_reg;
    logic                      signed_reg;
    logic                      wr_go;
    logic [0:0]                reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_go   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= mts_pkg::CAPACITY_RESET;
            signed_reg   <= mts_pkg::SIGNED_RESET;
        end else if (wr_go) begin
            case (reg_idx)
                mts_pkg::REG_CAPACITY: capacity_reg <= pwdata[mts_pkg::CAP_W-1:0];
                mts_pkg::REG_SIGNED:   signed_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            mts_pkg::REG_CAPACITY: prdata = mts_pkg::APB_DATA_W'(capacity_reg);
            mts_pkg::REG_SIGNED:   prdata = mts_pkg::APB_DATA_W'(signed_reg);
            default:               prdata = '0;
        endcase
    end

    assign cfg.capacity   = capacity_reg;
    assign cfg.signed_cmp = signed_reg;

endmodule

// ===== hdl/min_tracking_stack_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// Bounded stack with running minimum, kept in a value RAM and a min RAM.
// Input words (s_mode, s_push_value) push, pop or query; every word yields
// one result word on the m_ channel with status, popped value, new top,
// minimum, empty flag and count. Capacity and signedness sit behind the APB
// port. The operation is applied when a word is accepted, using cached tops, and
// the ST_FIN state picks up the new tops from the registered RAM reads after a pop.
// s_ready is low in ST_FIN, so a new word is taken only once the last is done.
// The result register parts the channels, so the next word is taken while a
// result waits; a stalled receiver holds further words only once the result
// register is full and a second result is ready. Reset empties both stacks
// at once (RAM contents are not cleared) and restores the register defaults.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
    parameter int DEPTH      = mts_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mts_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic signed [31:0]              s_push_value,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic signed [31:0]              m_popped_value,
    output logic signed [31:0]              m_top_value,
    output logic signed [31:0]              m_min_value,
    output logic                            m_is_empty,
    output logic [4:0]                      m_item_count
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > mts_pkg::CAP_W) ? CNT_W : mts_pkg::CAP_W;
    localparam logic [DATA_WIDTH-1:0] SIGN_MASK = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
    localparam logic [CNT_W-1:0]      CNT_FULL  = CNT_W'(DEPTH);

    typedef enum logic {ST_IDLE, ST_FIN} state_t;

    mts_pkg::cfg_t cfg;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    mcnt_reg, mcnt_next;
    logic [DATA_WIDTH-1:0] top_reg, top_next;
    logic [DATA_WIDTH-1:0] mtop_reg, mtop_next;
    logic                reload_top_reg, reload_top_next;
    logic                reload_min_reg, reload_min_next;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;
    logic [1:0]          status_reg, status_next;

    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [31:0]         m_popped_reg, m_top_reg, m_min_reg;
    logic                m_empty_reg;
    logic [4:0]          m_count_reg;

    logic                  accept, fin_go;
    logic [DATA_WIDTH-1:0] val;
    logic                  overflow, min_le, min_push, min_pop;
    logic [CNT_W-1:0]      cnt_m2, mcnt_m2;

    logic                  v_wr_en, m_wr_en, v_rd_en, m_rd_en;
    logic [DATA_WIDTH-1:0] v_rdata, m_rdata;
    logic [DATA_WIDTH-1:0] top_now, mtop_now;

    // configuration registers
    mts_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fin_go  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // operation decode on the cached tops
    assign val      = DATA_WIDTH'($unsigned(s_push_value));
    assign overflow = (CW'(cnt_reg) >= CW'(cfg.capacity)) || (cnt_reg == CNT_FULL);
    assign min_le   = cfg.signed_cmp ? ((val ^ SIGN_MASK) <= (mtop_reg ^ SIGN_MASK))
                                     : (val <= mtop_reg);
    assign min_push = (mcnt_reg != CNT_FULL) && ((mcnt_reg == '0) || min_le);
    assign min_pop  = (mcnt_reg != '0) && (mtop_reg == top_reg);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign mcnt_m2  = mcnt_reg - CNT_W'(2);

    always_comb begin
        cnt_next        = cnt_reg;
        mcnt_next       = mcnt_reg;
        top_next        = top_reg;
        mtop_next       = mtop_reg;
        reload_top_next = reload_top_reg;
        reload_min_next = reload_min_reg;
        popped_next     = popped_reg;
        status_next     = status_reg;
        v_wr_en         = 1'b0;
        m_wr_en         = 1'b0;
        v_rd_en         = 1'b0;
        m_rd_en         = 1'b0;
        if (accept) begin
            reload_top_next = 1'b0;
            reload_min_next = 1'b0;
            popped_next     = '0;
            status_next     = mts_pkg::STATUS_OK;
            case (s_mode)
                mts_pkg::MODE_PUSH: begin
                    if (overflow) begin
                        status_next = mts_pkg::STATUS_OVERFLOW;
                    end else begin
                        v_wr_en  = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        top_next = val;
                        if (min_push) begin
                            m_wr_en   = 1'b1;
                            mcnt_next = mcnt_reg + CNT_W'(1);
                            mtop_next = val;
                        end
                    end
                end
                mts_pkg::MODE_POP: begin
                    if (cnt_reg == '0) begin
                        status_next = mts_pkg::STATUS_UNDERFLOW;
                    end else begin
                        popped_next     = top_reg;
                        cnt_next        = cnt_reg - CNT_W'(1);
                        v_rd_en         = 1'b1;
                        reload_top_next = 1'b1;
                        if (min_pop) begin
                            mcnt_next       = mcnt_reg - CNT_W'(1);
                            m_rd_en         = 1'b1;
                            reload_min_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end else if (fin_go) begin
            top_next  = top_now;
            mtop_next = mtop_now;
        end
    end

    // value and min RAMs
    mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (v_wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (val),
        .rd_en   (v_rd_en),
        .rd_addr (cnt_m2[AW-1:0]),
        .rd_data (v_rdata)
    );

    mts_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_min_ram (
        .aclk    (aclk),
        .wr_en   (m_wr_en),
        .wr_addr (mcnt_reg[AW-1:0]),
        .wr_data (val),
        .rd_en   (m_rd_en),
        .rd_addr (mcnt_m2[AW-1:0]),
        .rd_data (m_rdata)
    );

    // tops after a pop come from the RAM read
    assign top_now  = reload_top_reg ? v_rdata : top_reg;
    assign mtop_now = reload_min_reg ? m_rdata : mtop_reg;

    // sequencer, stack state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            mcnt_reg       <= '0;
            reload_top_reg <= 1'b0;
            reload_min_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            mcnt_reg       <= mcnt_next;
            reload_top_reg <= reload_top_next;
            reload_min_reg <= reload_min_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        mtop_reg   <= mtop_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (fin_go) begin
            m_status_reg <= status_reg;
            m_popped_reg <= 32'(popped_reg);
            m_top_reg    <= (cnt_reg != '0) ? 32'(top_now) : '0;
            m_min_reg    <= (mcnt_reg != '0) ? 32'(mtop_now) : '0;
            m_empty_reg  <= (cnt_reg == '0);
            m_count_reg  <= 5'(cnt_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_popped_value = m_popped_reg;
    assign m_top_value    = m_top_reg;
    assign m_min_value    = m_min_reg;
    assign m_is_empty     = m_empty_reg;
    assign m_item_count   = m_count_reg;

`ifndef NO_ASSERTIONS
    // min stack never deeper than the value stack
    a_min_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        mcnt_reg <= cnt_reg)
        else $error("min stack deeper than value stack");

    // count stays within the storage
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("entry count beyond depth");

    // one word at a time in the sequencer
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("word accepted while busy");

    // a finished word lands in the result register with a matching empty flag
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> (m_valid_reg && (m_empty_reg == (cnt_reg == '0))))
        else $error("result register not loaded consistently");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min-tracking stack. Input words are pushes,
// pops, queries and the spare mode code. Every accepted word goes through a
// local model of both stacks, and the result words are checked field by field
// in order. A short table of directed words runs first. Several random phases
// follow, each with its own capacity, compare mode, push bias and idling
// pattern on the two channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int STACK_DEPTH     = mts_pkg::DEPTH_DEFAULT;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int DIRECTED_ROWS   = 27;
    // far beyond any stall streak at 68 percent idling
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    // mode codes that the package leaves unnamed
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // kinds of rows in the directed table
    localparam logic ROW_WORD = 1'b0;
    localparam logic ROW_CFG  = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped;
        logic [31:0] top;
        logic [31:0] minv;
        logic        empty;
        logic [4:0]  count;
    } stack_view_t;

    // reg_idx only matters on configuration rows, mode only on word rows
    typedef struct packed {
        logic        kind;
        logic [0:0]  reg_idx;
        logic [1:0]  mode;
        logic [31:0] value;
        logic        typed;
        stack_view_t view;
    } stim_row_t;

    localparam stack_view_t EMPTY_OK =
        '{mts_pkg::STATUS_OK, 32'h0, 32'h0, 32'h0, 1'b1, 5'd0};

    // clock, reset and block ports
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [mts_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [mts_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [mts_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode         = MODE_QUERY;
    logic signed [31:0] s_push_value = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_status;
    logic signed [31:0] m_popped_value;
    logic signed [31:0] m_top_value;
    logic signed [31:0] m_min_value;
    logic        m_is_empty;
    logic [4:0]  m_item_count;

    // model of both stacks and the registers
    logic [31:0] stk_values [STACK_DEPTH];
    logic [31:0] stk_mins   [STACK_DEPTH];
    int          value_depth    = 0;
    int          min_depth      = 0;
    int          cap_setting    = mts_pkg::CAPACITY_RESET;
    logic        signed_setting = mts_pkg::SIGNED_RESET;

    stack_view_t expected_views [$];

    // idling controls and run statistics
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int mismatches   = 0;
    int results_seen = 0;
    int words_sent   = 0;
    int push_words   = 0;
    int pop_words    = 0;
    int other_words  = 0;
    int overflows    = 0;
    int underflows   = 0;
    int deepest      = 0;
    int reg_writes   = 0;
    int stall_cycles = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty stack after reset: query, underflow, spare mode
        '{ROW_WORD, mts_pkg::REG_CAPACITY, MODE_QUERY, 32'h0, 1'b1, EMPTY_OK},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_UNDERFLOW, 32'h0, 32'h0, 32'h0, 1'b1, 5'd0}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, MODE_SPARE, 32'hFFFF_FFFF, 1'b1, EMPTY_OK},
        // signed extremes, an equal minimum twice, then unwind
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h8000_0000, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd2}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h8000_0000, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd3}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 5'd4}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd3}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd2}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 5'd0}},
        // unsigned compare
        '{ROW_CFG, mts_pkg::REG_SIGNED, mts_pkg::MODE_PUSH, 32'h0, 1'b0, '0},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h8000_0000, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd2}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h0000_0000, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'h0, 32'h0, 1'b0, 5'd3}},
        // full at capacity, then capacity dropped below the count
        '{ROW_CFG, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'd3, 1'b0, '0},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h1234_5678, 1'b1,
          '{mts_pkg::STATUS_OVERFLOW, 32'h0, 32'h0, 32'h0, 1'b0, 5'd3}},
        '{ROW_CFG, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'd1, 1'b0, '0},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd2}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'hAAAA_AAAA, 1'b1,
          '{mts_pkg::STATUS_OVERFLOW, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd2}},
        // zero capacity: pops still drain, every push overflows
        '{ROW_CFG, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'd0, 1'b0, '0},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_POP, 32'h0, 1'b1,
          '{mts_pkg::STATUS_OK, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 5'd0}},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h5555_5555, 1'b1,
          '{mts_pkg::STATUS_OVERFLOW, 32'h0, 32'h0, 32'h0, 1'b1, 5'd0}},
        // capacity above the depth, signed compare back on
        '{ROW_CFG, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'd31, 1'b0, '0},
        '{ROW_CFG, mts_pkg::REG_SIGNED, mts_pkg::MODE_PUSH, 32'd1, 1'b0, '0},
        '{ROW_WORD, mts_pkg::REG_CAPACITY, mts_pkg::MODE_PUSH, 32'h0000_0001, 1'b0, '0}
    };

    min_tracking_stack_top #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (mts_pkg::DATA_WIDTH_DEFAULT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_popped_value (m_popped_value),
        .m_top_value    (m_top_value),
        .m_min_value    (m_min_value),
        .m_is_empty     (m_is_empty),
        .m_item_count   (m_item_count)
    );

    // clock
    always #2 aclk = ~aclk;

    // ordering under the current compare mode
    function automatic bit value_le(input logic [31:0] a, input logic [31:0] b);
        return signed_setting ? ($signed(a) <= $signed(b)) : (a <= b);
    endfunction

    // apply one word to the model and return the view after it
    task automatic stack_model_step(input logic [1:0] mode, input logic [31:0] value,
                                    output stack_view_t view);
        int room;
        room = (cap_setting > STACK_DEPTH) ? STACK_DEPTH : cap_setting;
        view = '0;
        view.status = mts_pkg::STATUS_OK;
        if (mode == mts_pkg::MODE_PUSH) begin
            if (value_depth >= room) begin
                view.status = mts_pkg::STATUS_OVERFLOW;
            end else begin
                stk_values[value_depth] = value;
                value_depth++;
                if (min_depth < STACK_DEPTH &&
                    (min_depth == 0 || value_le(value, stk_mins[min_depth-1]))) begin
                    stk_mins[min_depth] = value;
                    min_depth++;
                end
            end
        end else if (mode == mts_pkg::MODE_POP) begin
            if (value_depth == 0) begin
                view.status = mts_pkg::STATUS_UNDERFLOW;
            end else begin
                view.popped = stk_values[value_depth-1];
                if (min_depth > 0 && stk_mins[min_depth-1] == view.popped)
                    min_depth--;
                value_depth--;
            end
        end
        view.top   = (value_depth > 0) ? stk_values[value_depth-1] : 32'h0;
        view.minv  = (min_depth > 0) ? stk_mins[min_depth-1] : 32'h0;
        view.empty = (value_depth == 0);
        view.count = value_depth[4:0];
    endtask

    // send one word, then queue what it should produce
    task automatic send_word(input logic [1:0] mode, input logic [31:0] value,
                             input logic typed, input stack_view_t typed_view);
        stack_view_t predicted;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_push_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        stack_model_step(mode, value, predicted);
        expected_views.push_back(typed ? typed_view : predicted);
        words_sent++;
        if (mode == mts_pkg::MODE_PUSH) push_words++;
        else if (mode == mts_pkg::MODE_POP) pop_words++;
        else other_words++;
        if (predicted.status == mts_pkg::STATUS_OVERFLOW) overflows++;
        if (predicted.status == mts_pkg::STATUS_UNDERFLOW) underflows++;
        if (value_depth > deepest) deepest = value_depth;
    endtask

    // register write once every pending result is back
    task automatic write_register(input logic [0:0] reg_idx, input logic [31:0] data);
        s_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == mts_pkg::REG_CAPACITY) cap_setting = data[mts_pkg::CAP_W-1:0];
        else signed_setting = data[0];
        reg_writes++;
    endtask

    // random value: wide, small and clustered, extremes, or the current minimum
    function automatic logic [31:0] pick_value();
        logic [31:0] extremes [4];
        int          roll;
        extremes = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        roll = $urandom_range(9);
        if (roll < 4) return $urandom;
        if (roll < 7) return 32'($urandom_range(7)) - 32'd4;
        if (roll == 7 || min_depth == 0) return extremes[$urandom_range(3)];
        return stk_mins[min_depth-1];
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result word checking
    always @(posedge aclk) begin : result_check
        stack_view_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_views.size() == 0) begin
                $display("%0t: result word with nothing expected, status %0d count %0d",
                         $time, m_status, m_item_count);
                mismatches++;
            end else begin
                want = expected_views.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("popped_value", want.popped, m_popped_value);
                check_field("top_value", want.top, m_top_value);
                check_field("min_value", want.minv, m_min_value);
                check_field("is_empty", 32'(want.empty), 32'(m_is_empty));
                check_field("item_count", 32'(want.count), 32'(m_item_count));
                results_seen++;
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    // progress watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_views.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int          phase_cap  [N_PHASES];
        logic        phase_sgn  [N_PHASES];
        int          phase_idle [N_PHASES];
        int          phase_push [N_PHASES];
        stim_row_t   row;
        logic [1:0]  mode;
        int          roll;

        // idling style per phase: 0 none, 1 sender, 2 receiver, 3 both
        phase_cap  = '{16, 16, 1, 31, 8, 5, 0, 12};
        phase_sgn  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_idle = '{0, 1, 2, 3, 0, 1, 2, 3};
        phase_push = '{60, 55, 50, 65, 50, 45, 30, 55};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_register(row.reg_idx, row.value);
            else
                send_word(row.mode, row.value, row.typed, row.view);
        end

        // random phases
        for (int p = 0; p < N_PHASES; p++) begin
            write_register(mts_pkg::REG_CAPACITY, 32'(phase_cap[p]));
            write_register(mts_pkg::REG_SIGNED, 32'(phase_sgn[p]));
            tx_idle_pct  = (phase_idle[p] == 1) ? 68 : (phase_idle[p] == 3) ? 11 : 0;
            rx_stall_pct = (phase_idle[p] == 2) ? 68 : (phase_idle[p] == 3) ? 11 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < phase_push[p]) mode = mts_pkg::MODE_PUSH;
                else if (roll < 90) mode = mts_pkg::MODE_POP;
                else if (roll < 97) mode = MODE_QUERY;
                else mode = MODE_SPARE;
                send_word(mode, pick_value(), 1'b0, '0);
            end
        end

        // drain and let the block settle
        s_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d words (%0d push, %0d pop, %0d query or spare), %0d results",
                 words_sent, push_words, pop_words, other_words, results_seen);
        $display("Saw %0d overflows, %0d underflows, depth up to %0d, %0d register writes",
                 overflows, underflows, deepest, reg_writes);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mts_pkg.sv
hdl/mts_ram.sv
hdl/mts_apb_regs.sv
hdl/min_tracking_stack_top.sv
verif/tb.sv
